// File: rtl/lens_undistort_coordinate_map_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lens undistortion coordinate map
// Shared property wrappers, clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef LENS_UNDISTORT_COORDINATE_MAP_UNIT_ASSERT_SVH
`define LENS_UNDISTORT_COORDINATE_MAP_UNIT_ASSERT_SVH

// same-cycle implication
`define LUDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LUDC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ludc_pkg.sv
// ----------------------------------------------------------------------------
// ludc_pkg
// Word types, register codes and fixed-point constants of the undistortion map.
// ----------------------------------------------------------------------------
`default_nettype none

package ludc_pkg;

    localparam int Q_FRAC  = 30;
    localparam int DIV_STG = 27;

    localparam logic signed [63:0] SAT_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ONE_Q   = 64'sh0000_0000_4000_0000;

    localparam logic signed [31:0] RST_K1 = -32'sd304307141;
    localparam logic signed [31:0] RST_K2 = 32'sd79412947;
    localparam logic signed [31:0] RST_P1 = 32'sd207866;
    localparam logic signed [31:0] RST_P2 = 32'sd18918;
    localparam logic [23:0]        RST_FX = 24'd1878647;
    localparam logic [23:0]        RST_FY = 24'd1873084;
    localparam logic [23:0]        RST_CX = 24'd1504113;
    localparam logic [23:0]        RST_CY = 24'd1017344;

    typedef enum logic [2:0] {
        REG_K1 = 3'd0,
        REG_K2 = 3'd1,
        REG_P1 = 3'd2,
        REG_P2 = 3'd3,
        REG_FX = 3'd4,
        REG_FY = 3'd5,
        REG_CX = 3'd6,
        REG_CY = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [9:0] out_col;
        logic [9:0] out_row;
    } t_in_word;

    typedef struct packed {
        logic [9:0] src_col;
        logic [9:0] src_row;
        logic       inside_res;
    } t_out_word;

    // restoring divider state: partial remainder and quotient/dividend word
    typedef struct packed {
        logic [23:0] rem;
        logic [53:0] quo;
    } t_div;

endpackage

`default_nettype wire

// File: rtl/ludc_smul.sv
// ----------------------------------------------------------------------------
// ludc_smul
// Signed Q30 multiply, truncated toward zero and saturated, four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ludc_smul (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [63:0] i_a,
    input  wire logic signed [63:0] i_b,
    output logic signed [63:0]      o_p
);
    import ludc_pkg::*;

    logic [63:0]        w_ma;
    logic [63:0]        w_mb;
    logic [61:0]        r_ma;
    logic [61:0]        r_mb;
    logic               r_neg1;
    logic               r_neg2;
    logic               r_neg3;
    logic [61:0]        r_p00;
    logic [61:0]        r_p01;
    logic [61:0]        r_p10;
    logic [61:0]        r_p11;
    logic [123:0]       r_full;
    logic [63:0]        w_mag;
    logic signed [63:0] r_p;

    assign w_ma = i_a[63] ? 64'(-i_a) : 64'(i_a);
    assign w_mb = i_b[63] ? 64'(-i_b) : 64'(i_b);

    assign w_mag = (|r_full[123:92]) ? 64'(SAT_LIM) : {2'b00, r_full[91:30]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= w_ma[61:0];
            r_mb   <= w_mb[61:0];
            r_neg1 <= i_a[63] ^ i_b[63];

            r_p00  <= r_ma[30:0] * r_mb[30:0];
            r_p01  <= r_ma[30:0] * r_mb[61:31];
            r_p10  <= r_ma[61:31] * r_mb[30:0];
            r_p11  <= r_ma[61:31] * r_mb[61:31];
            r_neg2 <= r_neg1;

            r_full <= (124'(r_p11) << 62) + ((124'(r_p01) + 124'(r_p10)) << 31)
                    + 124'(r_p00);
            r_neg3 <= r_neg2;

            r_p    <= r_neg3 ? -$signed(w_mag) : $signed(w_mag);
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// File: rtl/lens_undistort_coordinate_map_unit.sv
// ----------------------------------------------------------------------------
// lens_undistort_coordinate_map_unit
// Maps an undistorted pixel to its source pixel in the distorted image
// (two radial and two tangential lens terms, Q30 fixed point).
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------
//  in      | i_valid / o_ready    | i_word  (out_col, out_row)
//  out     | o_valid / i_ready    | o_word  (src_col, src_row, inside_res)
//  cfg     | i_cfg_we             | i_cfg_idx, i_cfg_data
//
//  One word per cycle while o_ready is high; each word passes through the
//  27-stage radix-2x2 divider and five rounds of 4-stage multiplies.
//  Synchronous active-low reset clears valids and loads the register defaults.
//  A skid register behind the output register lets the pipe take one more word
//  per stall; o_ready drops only once the skid holds a word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lens_undistort_coordinate_map_unit_assert.svh"

module lens_undistort_coordinate_map_unit #(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_idx,
    input  wire logic [31:0]         i_cfg_data,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire ludc_pkg::t_in_word  i_word,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output ludc_pkg::t_out_word      o_word
);
    import ludc_pkg::*;

    localparam int N_STG = 56;
    localparam logic signed [63:0] W_LIM = 64'(IMAGE_WIDTH) <<< Q_FRAC;
    localparam logic signed [63:0] H_LIM = 64'(IMAGE_HEIGHT) <<< Q_FRAC;

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = 65'(a) + 65'(b);
        if (s > 65'(SAT_LIM)) begin
            r = SAT_LIM;
        end else if (s < -65'(SAT_LIM)) begin
            r = -SAT_LIM;
        end else begin
            r = s[63:0];
        end
        return r;
    endfunction

    function automatic t_div div2(input t_div s, input logic [23:0] f);
        t_div        r;
        logic [24:0] t;
        int          i;
        r = s;
        for (i = 0; i < 2; i++) begin
            t = {r.rem, r.quo[53]};
            r.quo = {r.quo[52:0], 1'b0};
            if (t >= {1'b0, f}) begin
                t = t - {1'b0, f};
                r.quo[0] = 1'b1;
            end
            r.rem = t[23:0];
        end
        return r;
    endfunction

    // configuration
    logic signed [31:0] r_k1, r_k2, r_p1, r_p2;
    logic [23:0]        r_fx, r_fy, r_cx, r_cy;
    logic [23:0]        w_fx, w_fy;
    logic signed [63:0] w_k1, w_k2, w_p1, w_p2, w_fxs, w_fys, w_cxs, w_cys;

    // control
    logic               w_en;
    logic [N_STG-1:0]   r_vld;
    logic               w_tail_go;
    logic               w_out_free;
    t_out_word          r_out, n_out, r_skd, n_skd;
    logic               r_out_vld, n_out_vld, r_skd_vld, n_skd_vld;

    // normalize / divide
    logic signed [25:0] w_dx, w_dy;
    logic [25:0]        w_mx, w_my;
    t_div               r_dvx [0:DIV_STG];
    t_div               r_dvy [0:DIV_STG];
    logic [DIV_STG:0]   r_sgx, r_sgy;

    // datapath
    logic signed [63:0] r_xp [0:15];
    logic signed [63:0] r_yp [0:15];
    logic signed [63:0] w_x2, w_y2, w_xy;
    logic signed [63:0] r_r2, r_txy, r_x2d, r_y2d;
    logic signed [63:0] r_tx, r_ty, r_r2b, r_txyb;
    logic signed [63:0] w_r4, w_kr2, w_ptx, w_pty, w_px, w_py, w_k2r4;
    logic signed [63:0] r_rad0 [0:3];
    logic signed [63:0] r_rad;
    logic signed [63:0] r_ax1 [0:8];
    logic signed [63:0] r_ay1 [0:8];
    logic signed [63:0] r_ax2 [0:9];
    logic signed [63:0] r_ay2 [0:9];
    logic signed [63:0] w_xr, w_yr;
    logic signed [63:0] r_sx, r_sy, r_xd, r_yd;
    logic signed [63:0] w_uf, w_vf;
    logic signed [63:0] r_u, r_v;
    t_out_word          r_res;
    logic               w_inside;

    assign w_fx  = (r_fx == '0) ? 24'd1 : r_fx;
    assign w_fy  = (r_fy == '0) ? 24'd1 : r_fy;
    assign w_k1  = 64'(r_k1);
    assign w_k2  = 64'(r_k2);
    assign w_p1  = 64'(r_p1);
    assign w_p2  = 64'(r_p2);
    assign w_fxs = $signed(64'(w_fx) << 18);
    assign w_fys = $signed(64'(w_fy) << 18);
    assign w_cxs = $signed(64'(r_cx) << 18);
    assign w_cys = $signed(64'(r_cy) << 18);

    assign w_en    = !r_skd_vld;
    assign o_ready = w_en;

    assign w_dx = $signed(26'({i_word.out_col, 12'b0})) - $signed(26'(r_cx));
    assign w_dy = $signed(26'({i_word.out_row, 12'b0})) - $signed(26'(r_cy));
    assign w_mx = w_dx[25] ? 26'(-w_dx) : 26'(w_dx);
    assign w_my = w_dy[25] ? 26'(-w_dy) : 26'(w_dy);

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1      <= RST_K1;
            r_k2      <= RST_K2;
            r_p1      <= RST_P1;
            r_p2      <= RST_P2;
            r_fx      <= RST_FX;
            r_fy      <= RST_FY;
            r_cx      <= RST_CX;
            r_cy      <= RST_CY;
            r_vld     <= '0;
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_K1: r_k1 <= i_cfg_data;
                    REG_K2: r_k2 <= i_cfg_data;
                    REG_P1: r_p1 <= i_cfg_data;
                    REG_P2: r_p2 <= i_cfg_data;
                    REG_FX: r_fx <= i_cfg_data[23:0];
                    REG_FY: r_fy <= i_cfg_data[23:0];
                    REG_CX: r_cx <= i_cfg_data[23:0];
                    REG_CY: r_cy <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (w_en) begin
                r_vld <= {r_vld[N_STG-2:0], i_valid};
            end
            r_out_vld <= n_out_vld;
            r_skd_vld <= n_skd_vld;
        end
    end

    // divider
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dvx[0] <= '{rem: '0, quo: {w_mx[23:0], 30'b0}};
            r_dvy[0] <= '{rem: '0, quo: {w_my[23:0], 30'b0}};
            r_sgx    <= {r_sgx[DIV_STG-1:0], w_dx[25]};
            r_sgy    <= {r_sgy[DIV_STG-1:0], w_dy[25]};
            for (int k = 1; k <= DIV_STG; k++) begin
                r_dvx[k] <= div2(r_dvx[k-1], w_fx);
                r_dvy[k] <= div2(r_dvy[k-1], w_fy);
            end
        end
    end

    // multipliers
    ludc_smul u_mul_x2  (.i_clk, .i_en(w_en), .i_a(r_xp[0]), .i_b(r_xp[0]), .o_p(w_x2));
    ludc_smul u_mul_y2  (.i_clk, .i_en(w_en), .i_a(r_yp[0]), .i_b(r_yp[0]), .o_p(w_y2));
    ludc_smul u_mul_xy  (.i_clk, .i_en(w_en), .i_a(r_xp[0]), .i_b(r_yp[0]), .o_p(w_xy));
    ludc_smul u_mul_r4  (.i_clk, .i_en(w_en), .i_a(r_r2b),   .i_b(r_r2b),   .o_p(w_r4));
    ludc_smul u_mul_kr2 (.i_clk, .i_en(w_en), .i_a(w_k1),    .i_b(r_r2b),   .o_p(w_kr2));
    ludc_smul u_mul_ptx (.i_clk, .i_en(w_en), .i_a(w_p1),    .i_b(r_txyb),  .o_p(w_ptx));
    ludc_smul u_mul_pty (.i_clk, .i_en(w_en), .i_a(w_p2),    .i_b(r_txyb),  .o_p(w_pty));
    ludc_smul u_mul_px  (.i_clk, .i_en(w_en), .i_a(w_p2),    .i_b(r_tx),    .o_p(w_px));
    ludc_smul u_mul_py  (.i_clk, .i_en(w_en), .i_a(w_p1),    .i_b(r_ty),    .o_p(w_py));
    ludc_smul u_mul_k2  (.i_clk, .i_en(w_en), .i_a(w_k2),    .i_b(w_r4),    .o_p(w_k2r4));
    ludc_smul u_mul_xr  (.i_clk, .i_en(w_en), .i_a(r_xp[15]), .i_b(r_rad),  .o_p(w_xr));
    ludc_smul u_mul_yr  (.i_clk, .i_en(w_en), .i_a(r_yp[15]), .i_b(r_rad),  .o_p(w_yr));
    ludc_smul u_mul_u   (.i_clk, .i_en(w_en), .i_a(r_xd),    .i_b(w_fxs),   .o_p(w_uf));
    ludc_smul u_mul_v   (.i_clk, .i_en(w_en), .i_a(r_yd),    .i_b(w_fys),   .o_p(w_vf));

    assign w_inside = (r_u >= 0) && (r_v >= 0) && (r_u < W_LIM) && (r_v < H_LIM);

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xp[0] <= r_sgx[DIV_STG] ? -$signed(64'(r_dvx[DIV_STG].quo))
                                      : $signed(64'(r_dvx[DIV_STG].quo));
            r_yp[0] <= r_sgy[DIV_STG] ? -$signed(64'(r_dvy[DIV_STG].quo))
                                      : $signed(64'(r_dvy[DIV_STG].quo));
            for (int k = 1; k < 16; k++) begin
                r_xp[k] <= r_xp[k-1];
                r_yp[k] <= r_yp[k-1];
            end

            r_r2   <= sadd(w_x2, w_y2);
            r_txy  <= sadd(w_xy, w_xy);
            r_x2d  <= sadd(w_x2, w_x2);
            r_y2d  <= sadd(w_y2, w_y2);

            r_tx   <= sadd(r_r2, r_x2d);
            r_ty   <= sadd(r_r2, r_y2d);
            r_r2b  <= r_r2;
            r_txyb <= r_txy;

            r_rad0[0] <= sadd(ONE_Q, w_kr2);
            for (int k = 1; k < 4; k++) begin
                r_rad0[k] <= r_rad0[k-1];
            end
            r_rad <= sadd(r_rad0[3], w_k2r4);

            r_ax1[0] <= w_ptx;
            r_ay1[0] <= w_py;
            for (int k = 1; k < 9; k++) begin
                r_ax1[k] <= r_ax1[k-1];
                r_ay1[k] <= r_ay1[k-1];
            end
            r_ax2[0] <= w_px;
            r_ay2[0] <= w_pty;
            for (int k = 1; k < 10; k++) begin
                r_ax2[k] <= r_ax2[k-1];
                r_ay2[k] <= r_ay2[k-1];
            end

            r_sx <= sadd(w_xr, r_ax1[8]);
            r_sy <= sadd(w_yr, r_ay1[8]);
            r_xd <= sadd(r_sx, r_ax2[9]);
            r_yd <= sadd(r_sy, r_ay2[9]);

            r_u  <= sadd(w_uf, w_cxs);
            r_v  <= sadd(w_vf, w_cys);

            r_res.inside_res <= w_inside;
            r_res.src_col    <= w_inside ? r_u[39:30] : '0;
            r_res.src_row    <= w_inside ? r_v[39:30] : '0;
        end
    end

    // output register and skid
    assign w_tail_go  = w_en && r_vld[N_STG-1];
    assign w_out_free = !r_out_vld || i_ready;

    always_comb begin
        n_out     = r_out;
        n_out_vld = r_out_vld;
        n_skd     = r_skd;
        n_skd_vld = r_skd_vld;
        if (w_out_free) begin
            if (r_skd_vld) begin
                n_out     = r_skd;
                n_out_vld = 1'b1;
                n_skd_vld = 1'b0;
            end else begin
                n_out     = r_res;
                n_out_vld = w_tail_go;
            end
        end else if (w_tail_go) begin
            n_skd     = r_res;
            n_skd_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_skd <= n_skd;
    end

    assign o_valid = r_out_vld;
    assign o_word  = r_out;

    `LUDC_ASSERT_NOW(a_skd_has_out, r_skd_vld, r_out_vld, "skid full with empty output")
    `LUDC_ASSERT_NOW(a_outside_zero, o_valid && !o_word.inside_res,
        o_word.src_col == '0 && o_word.src_row == '0, "outside word has nonzero coordinate")
    `LUDC_ASSERT_NOW(a_skd_fill, $rose(r_skd_vld), $past(r_out_vld && !i_ready),
        "skid filled while output was free")
    `LUDC_ASSERT_NXT(a_accept_enters, i_valid && o_ready, r_vld[0],
        "accepted word missing from first stage")

endmodule

`default_nettype wire

// File: sim/tb_lens_undistort_coordinate_map_unit.sv
// ----------------------------------------------------------------------------
// Testbench for lens_undistort_coordinate_map_unit
// Drives pixel coordinates through the valid/ready input with bursty gaps,
// stalls the output at random and checks every result word against an
// in-bench fixed-point Brown-Conrady predictor across several register sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_lens_undistort_coordinate_map_unit;
    import ludc_pkg::*;

    localparam int  IMG_W     = 1024;
    localparam int  IMG_H     = 1024;
    localparam int  LATENCY   = 56;
    localparam int  MAX_CYC   = 400000;
    localparam longint LIMQ   = 64'sh3FFF_FFFF_FFFF_FFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    t_in_word    i_word;
    logic        o_valid;
    logic        i_ready;
    t_out_word   o_word;

    lens_undistort_coordinate_map_unit #(
        .IMAGE_WIDTH (IMG_W),
        .IMAGE_HEIGHT(IMG_H)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_word    (i_word),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_word    (o_word)
    );

    logic [31:0] lens_k1, lens_k2, lens_p1, lens_p2;
    logic [23:0] lens_fx, lens_fy, lens_cx, lens_cy;

    t_out_word   pending_map[$];
    int          mismatches;
    longint      cycles;
    int          burst_left;
    int          stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clip(input longint v);
        if (v > LIMQ) return LIMQ;
        if (v < -LIMQ) return -LIMQ;
        return v;
    endfunction

    function automatic longint qadd(input longint a, input longint b);
        return clip(a + b);
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        logic [127:0] ma, mb, p, r;
        logic         neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? 128'(-a) : 128'(a);
        mb  = (b < 0) ? 128'(-b) : 128'(b);
        p   = ma * mb;
        r   = p >> 30;
        if (r[127:62] != 0) r = 128'(LIMQ);
        return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    function automatic longint norm_q(input logic [9:0] pix, input logic [23:0] c,
                                      input logic [23:0] f);
        longint       d;
        logic [63:0]  mag;
        d   = longint'({pix, 12'd0}) - longint'(c);
        mag = (d < 0) ? 64'(-d) : 64'(d);
        mag = (mag << 30) / 64'((f == 0) ? 24'd1 : f);
        return (d < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic t_out_word map_coord(input t_in_word w);
        longint    k1, k2, p1, p2, x, y, x2, y2, xy, r2, r4, txy, rad, xd, yd, u, v;
        logic [23:0] fx, fy;
        t_out_word r;
        k1 = longint'(signed'(lens_k1));
        k2 = longint'(signed'(lens_k2));
        p1 = longint'(signed'(lens_p1));
        p2 = longint'(signed'(lens_p2));
        fx = (lens_fx == 0) ? 24'd1 : lens_fx;
        fy = (lens_fy == 0) ? 24'd1 : lens_fy;
        x  = norm_q(w.out_col, lens_cx, fx);
        y  = norm_q(w.out_row, lens_cy, fy);
        x2 = qmul(x, x);
        y2 = qmul(y, y);
        xy = qmul(x, y);
        r2 = qadd(x2, y2);
        r4 = qmul(r2, r2);
        txy = qadd(xy, xy);
        rad = qadd(qadd(longint'(1) << 30, qmul(k1, r2)), qmul(k2, r4));
        xd = qadd(qadd(qmul(x, rad), qmul(p1, txy)), qmul(p2, qadd(r2, qadd(x2, x2))));
        yd = qadd(qadd(qmul(y, rad), qmul(p1, qadd(r2, qadd(y2, y2)))), qmul(p2, txy));
        u  = qadd(qmul(xd, longint'(fx) << 18), longint'(lens_cx) << 18);
        v  = qadd(qmul(yd, longint'(fy) << 18), longint'(lens_cy) << 18);
        r  = '0;
        if (u >= 0 && v >= 0 && u < (longint'(IMG_W) << 30) && v < (longint'(IMG_H) << 30))
        begin
            r.src_col    = u[39:30];
            r.src_row    = v[39:30];
            r.inside_res = 1'b1;
        end
        return r;
    endfunction

    // output stall pattern
    always @(negedge i_clk) begin
        if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            2: i_ready <= ($urandom_range(0, 1) != 0);
            default: i_ready <= ((cycles / 7) % 3 != 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_map.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", o_word);
            end else begin
                exp_w = pending_map.pop_front();
                if (o_word.src_col !== exp_w.src_col || o_word.src_row !== exp_w.src_row ||
                    o_word.inside_res !== exp_w.inside_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp col %0d row %0d in %0d, got col %0d row %0d in %0d",
                                 exp_w.src_col, exp_w.src_row, exp_w.inside_res,
                                 o_word.src_col, o_word.src_row, o_word.inside_res);
                end
            end
        end
    end

    task automatic send_coord(input logic [9:0] col, input logic [9:0] row);
        t_in_word w;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        w.out_col = col;
        w.out_row = row;
        i_word  <= w;
        i_valid <= 1'b1;
        pending_map.push_back(map_coord(w));
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (burst_left == 0) i_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending_map.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_K1: lens_k1 = val;
            REG_K2: lens_k2 = val;
            REG_P1: lens_p1 = val;
            REG_P2: lens_p2 = val;
            REG_FX: lens_fx = val[23:0];
            REG_FY: lens_fy = val[23:0];
            REG_CX: lens_cx = val[23:0];
            default: lens_cy = val[23:0];
        endcase
    endtask

    task automatic load_lens(input logic [31:0] k1, input logic [31:0] k2,
                             input logic [31:0] p1, input logic [31:0] p2,
                             input logic [23:0] fx, input logic [23:0] fy,
                             input logic [23:0] cx, input logic [23:0] cy);
        write_reg(REG_K1, k1);
        write_reg(REG_K2, k2);
        write_reg(REG_P1, p1);
        write_reg(REG_P2, p2);
        write_reg(REG_FX, {8'd0, fx});
        write_reg(REG_FY, {8'd0, fy});
        write_reg(REG_CX, {8'd0, cx});
        write_reg(REG_CY, {8'd0, cy});
    endtask

    task automatic test_corners();
        send_coord(10'd0, 10'd0);
        send_coord(10'd1023, 10'd0);
        send_coord(10'd0, 10'd1023);
        send_coord(10'd1023, 10'd1023);
        send_coord(10'd367, 10'd248);
        send_coord(10'd512, 10'd512);
        send_coord(10'h2AA, 10'h155);
        send_coord(10'h155, 10'h2AA);
    endtask

    task automatic test_random_coords(input int n);
        repeat (n) send_coord($urandom_range(0, 1023), $urandom_range(0, 1023));
    endtask

    task automatic test_identity_lens();
        wait_idle();
        load_lens(32'd0, 32'd0, 32'd0, 32'd0, 24'd4096, 24'd4096, 24'd0, 24'd0);
        test_corners();
        test_random_coords(60);
    endtask

    task automatic test_extreme_regs();
        wait_idle();
        // zero focal lengths and saturating coefficients
        load_lens(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  24'd0, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF);
        test_corners();
        wait_idle();
        load_lens(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  24'hFF_FFFF, 24'hFF_FFFF, 24'd0, 24'd0);
        test_corners();
        test_random_coords(20);
    endtask

    task automatic test_random_lens(input int sets, input int n);
        repeat (sets) begin
            wait_idle();
            load_lens($urandom_range(0, 3) == 0 ? $urandom : 32'($signed($urandom) >>> 4),
                      $urandom_range(0, 3) == 0 ? $urandom : 32'($signed($urandom) >>> 6),
                      32'($signed($urandom) >>> $urandom_range(8, 31)),
                      32'($signed($urandom) >>> $urandom_range(8, 31)),
                      ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(800000, 5000000)),
                      ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(800000, 5000000)),
                      ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4194303)),
                      ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4194303)));
            test_random_coords(n);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = 3'd0;
        i_cfg_data = 32'd0;
        i_valid    = 1'b0;
        i_ready    = 1'b0;
        i_word     = '0;
        mismatches = 0;
        cycles     = 0;
        burst_left = 0;
        stall_mode = 0;
        lens_k1 = RST_K1; lens_k2 = RST_K2; lens_p1 = RST_P1; lens_p2 = RST_P2;
        lens_fx = RST_FX; lens_fy = RST_FY; lens_cx = RST_CX; lens_cy = RST_CY;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_corners();
        test_random_coords(200);
        test_identity_lens();
        test_extreme_regs();
        test_random_lens(6, 80);

        wait_idle();
        if (mismatches == 0 && pending_map.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
